[design/weighted_random_select_unit_assert.svh]
// Assertion macros for the weighted random select unit; they use the enclosing clk and arst_n.
`ifndef WEIGHTED_RANDOM_SELECT_UNIT_ASSERT_SVH
`define WEIGHTED_RANDOM_SELECT_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checks that a property holds at every clock edge outside reset.
`define WRS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checks that a condition is never true at a clock edge outside reset.
`define WRS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define WRS_ASSERT(lbl, prop, msg)
`define WRS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[design/wrs_pkg.sv]
// Shared types and constants for the weighted random select unit.
`default_nettype none

package wrs_pkg;

	localparam int DATA_W          = 14;
	localparam int IDX_OUT_W       = 7;
	localparam int CNT_W           = 8;
	localparam int MAX_OPTIONS_DEF = 128;

	localparam logic [DATA_W-1:0] SCALE = 14'd10000;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_SELECT = 2'd1,
		CMD_CHANCE = 2'd2
	} cmd_t;

	// Control part of the selection token that walks the cell chain.
	typedef struct packed {
		logic valid;
		logic found;
	} tok_ctl_t;

endpackage

`default_nettype wire

[design/wrs_cell.sv]
// One cell of the selection chain: holds one weight and steps the token past it.
`default_nettype none

module wrs_cell #(
	parameter int MAX_OPTIONS = wrs_pkg::MAX_OPTIONS_DEF,
	parameter int CELL_INDEX  = 0
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [wrs_pkg::IDX_OUT_W-1:0]    wr_index,
	input  wire logic [wrs_pkg::DATA_W-1:0]       wr_data,
	input  wire logic [wrs_pkg::CNT_W-1:0]        option_count,
	input  wire wrs_pkg::tok_ctl_t                tok_in,
	input  wire logic [wrs_pkg::DATA_W-1:0]       rem_in,
	input  wire logic [$clog2(MAX_OPTIONS)-1:0]   pick_in,
	output wrs_pkg::tok_ctl_t                     tok_out,
	output logic [wrs_pkg::DATA_W-1:0]            rem_out,
	output logic [$clog2(MAX_OPTIONS)-1:0]        pick_out
);

	localparam int IdxW = $clog2(MAX_OPTIONS);
	localparam int CmpW = (IdxW + 1 > wrs_pkg::CNT_W) ? IdxW + 1 : wrs_pkg::CNT_W;
	localparam logic [CmpW-1:0] MyIdx  = CmpW'(CELL_INDEX);
	localparam logic [IdxW-1:0] MyPick = IdxW'(CELL_INDEX);

	logic [wrs_pkg::DATA_W-1:0] weight_q;
	wrs_pkg::tok_ctl_t          tok_d;
	wrs_pkg::tok_ctl_t          tok_q;
	logic [wrs_pkg::DATA_W-1:0] rem_d;
	logic [wrs_pkg::DATA_W-1:0] rem_q;
	logic [IdxW-1:0]            pick_d;
	logic [IdxW-1:0]            pick_q;
	logic                       wr_hit;
	logic                       active;

	assign wr_hit = wr_en && (CmpW'(wr_index) == MyIdx);
	// Cells at or beyond the configured count pass the token through untouched.
	assign active = CmpW'(option_count) > MyIdx;

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			weight_q <= wr_data;
		end
	end

	always_comb begin
		tok_d  = tok_in;
		rem_d  = rem_in;
		pick_d = pick_in;
		if (tok_in.valid && !tok_in.found && active) begin
			if (rem_in <= weight_q) begin
				tok_d.found = 1'b1;
				pick_d      = MyPick;
			end else begin
				rem_d = rem_in - weight_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_d;
		pick_q <= pick_d;
	end

	assign tok_out  = tok_q;
	assign rem_out  = rem_q;
	assign pick_out = pick_q;

endmodule

`default_nettype wire

[design/weighted_random_select_unit.sv]
// Top level of the weighted random select unit: command decode, cell chain and result register.
//
//   Channel | Direction | Handshake          | Fields
//   in      | input     | in_valid/in_stall  | command, entry_index, weight_value,
//           |           |                    | chance_value, draw
//   out     | output    | out_valid/out_stall| selected_index, chance_true, sum_short
//   cfg     | input     | cfg_wr_en          | cfg_wr_data (option_count)
//
// A weight write gives no result. A chance test gives its result
// in the cycle after it is taken. A select sends a token down a chain of MAX_OPTIONS
// cells, one cell per cycle, and the token out of the last cell loads the result register;
// no new transaction is taken while the token is in the chain.
// Reset clears control state only; weights hold nothing until written.
// A stalled result holds the output register and stalls the input side in turn.
`default_nettype none

module weighted_random_select_unit #(
	parameter int MAX_OPTIONS = wrs_pkg::MAX_OPTIONS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [wrs_pkg::CNT_W-1:0]       cfg_wr_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      command,
	input  wire logic [wrs_pkg::IDX_OUT_W-1:0]   entry_index,
	input  wire logic [wrs_pkg::DATA_W-1:0]      weight_value,
	input  wire logic [wrs_pkg::DATA_W-1:0]      chance_value,
	input  wire logic [wrs_pkg::DATA_W-1:0]      draw,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [wrs_pkg::IDX_OUT_W-1:0]        selected_index,
	output logic                                 chance_true,
	output logic                                 sum_short
);

	`include "weighted_random_select_unit_assert.svh"

	localparam int IdxW = $clog2(MAX_OPTIONS);

	logic [wrs_pkg::CNT_W-1:0]     option_count_q;
	logic                          sel_busy_q;
	logic                          out_valid_q;
	logic [wrs_pkg::IDX_OUT_W-1:0] selected_index_q;
	logic                          chance_true_q;
	logic                          sum_short_q;

	logic                          in_acc;
	logic                          do_write;
	logic                          do_select;
	logic                          do_chance;
	logic [wrs_pkg::DATA_W-1:0]    weight_sat;
	logic                          chance_hit;

	wrs_pkg::tok_ctl_t             tok_c  [MAX_OPTIONS+1];
	logic [wrs_pkg::DATA_W-1:0]    rem_c  [MAX_OPTIONS+1];
	logic [IdxW-1:0]               pick_c [MAX_OPTIONS+1];
	logic [MAX_OPTIONS-1:0]        tok_valid_vec;
	wrs_pkg::tok_ctl_t             tok_last;

	assign in_stall = sel_busy_q | (out_valid_q & out_stall);
	assign in_acc   = in_valid & ~in_stall;

	always_comb begin
		do_write  = 1'b0;
		do_select = 1'b0;
		do_chance = 1'b0;
		unique case (command)
			wrs_pkg::CMD_WRITE:  do_write  = in_acc;
			wrs_pkg::CMD_SELECT: do_select = in_acc;
			wrs_pkg::CMD_CHANCE: do_chance = in_acc;
			default: ;
		endcase
	end

	assign weight_sat = (weight_value > wrs_pkg::SCALE) ? wrs_pkg::SCALE : weight_value;
	assign chance_hit = (chance_value != '0) && (draw <= chance_value);

	// A new select enters the chain as a fresh token carrying the whole draw.
	assign tok_c[0].valid = do_select;
	assign tok_c[0].found = 1'b0;
	assign rem_c[0]       = draw;
	assign pick_c[0]      = '0;

	for (genvar i = 0; i < MAX_OPTIONS; i++) begin : g_cell
		wrs_cell #(
			.MAX_OPTIONS (MAX_OPTIONS),
			.CELL_INDEX  (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.wr_en        (do_write),
			.wr_index     (entry_index),
			.wr_data      (weight_sat),
			.option_count (option_count_q),
			.tok_in       (tok_c[i]),
			.rem_in       (rem_c[i]),
			.pick_in      (pick_c[i]),
			.tok_out      (tok_c[i+1]),
			.rem_out      (rem_c[i+1]),
			.pick_out     (pick_c[i+1])
		);
		assign tok_valid_vec[i] = tok_c[i+1].valid;
	end

	assign tok_last = tok_c[MAX_OPTIONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			option_count_q <= wrs_pkg::CNT_W'(1);
		end else if (cfg_wr_en) begin
			option_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_busy_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_select) begin
				sel_busy_q <= 1'b1;
			end else if (tok_last.valid) begin
				sel_busy_q <= 1'b0;
			end
			if (do_chance || tok_last.valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_chance) begin
			selected_index_q <= '0;
			chance_true_q    <= chance_hit;
			sum_short_q      <= 1'b0;
		end else if (tok_last.valid) begin
			selected_index_q <= wrs_pkg::IDX_OUT_W'(pick_c[MAX_OPTIONS]);
			chance_true_q    <= 1'b0;
			sum_short_q      <= ~tok_last.found;
		end
	end

	assign out_valid      = out_valid_q;
	assign selected_index = selected_index_q;
	assign chance_true    = chance_true_q;
	assign sum_short      = sum_short_q;

	`WRS_ASSERT_NEVER(a_no_overwrite, tok_last.valid && out_valid_q, "result register overrun")
	`WRS_ASSERT(a_one_token_busy, sel_busy_q |-> ($countones(tok_valid_vec) == 1), "token count")
	`WRS_ASSERT(a_no_token_idle, !sel_busy_q |-> (tok_valid_vec == '0), "token while idle")
	`WRS_ASSERT(a_select_busy, do_select |=> sel_busy_q, "select taken but chain not busy")

endmodule

`default_nettype wire

[bench/tb_weighted_random_select_unit.sv]
// Self-checking testbench for the weighted random select unit: directed and random command streams.
`timescale 1ns / 1ps

module tb_weighted_random_select_unit;

	localparam int NUM_OPTIONS = wrs_pkg::MAX_OPTIONS_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int DRAIN_LIMIT = 50000;
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AFTER = 150;
	localparam int REPORT_MAX = 10;
	localparam int PHASE_ITEMS = 120;

	typedef logic [wrs_pkg::DATA_W-1:0]    data_t;
	typedef logic [wrs_pkg::IDX_OUT_W-1:0] idx_t;
	typedef logic [wrs_pkg::CNT_W-1:0]     cnt_t;

	typedef struct packed {
		logic [wrs_pkg::IDX_OUT_W-1:0] idx;
		logic                          chance_hit;
		logic                          over_sum;
	} pick_t;

	// Tracks the weight table and option count, and holds the picks still to come out.
	class pick_tracker;
		logic [wrs_pkg::DATA_W-1:0] weights [NUM_OPTIONS];
		int unsigned                opt_count;
		pick_t                      pending_picks [$];
		int unsigned                fail_count;
		int unsigned                checked;

		function new();
			foreach (weights[i]) weights[i] = '0;
			opt_count = 1;
			fail_count = 0;
			checked = 0;
		endfunction

		function int unsigned outstanding();
			return pending_picks.size();
		endfunction

		function void take_command(input logic [1:0] cmd,
				input logic [wrs_pkg::IDX_OUT_W-1:0] idx,
				input logic [wrs_pkg::DATA_W-1:0] wv, input logic [wrs_pkg::DATA_W-1:0] cv,
				input logic [wrs_pkg::DATA_W-1:0] dr);
			pick_t       p;
			int unsigned n;
			int unsigned rem;
			bit          found;
			p = '0;
			case (cmd)
				wrs_pkg::CMD_WRITE: begin
					if (idx < NUM_OPTIONS)
						weights[idx] = (wv > wrs_pkg::SCALE) ? wrs_pkg::SCALE : wv;
				end
				wrs_pkg::CMD_SELECT: begin
					n = (opt_count > NUM_OPTIONS) ? NUM_OPTIONS : opt_count;
					rem = dr;
					found = 1'b0;
					for (int i = 0; i < n && !found; i++) begin
						if (rem <= weights[i]) begin
							p.idx = i[wrs_pkg::IDX_OUT_W-1:0];
							found = 1'b1;
						end else begin
							rem -= weights[i];
						end
					end
					p.over_sum = !found;
					pending_picks.push_back(p);
				end
				wrs_pkg::CMD_CHANCE: begin
					p.chance_hit = (cv != 0) && (dr <= cv);
					pending_picks.push_back(p);
				end
				default: ;
			endcase
		endfunction

		function void check_pick(input logic [wrs_pkg::IDX_OUT_W-1:0] idx, input logic hit,
				input logic over);
			pick_t want;
			checked++;
			if (pending_picks.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected result: idx=%0d chance=%0b short=%0b", idx, hit, over);
				return;
			end
			want = pending_picks.pop_front();
			if (idx !== want.idx || hit !== want.chance_hit || over !== want.over_sum) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("result mismatch: expected idx=%0d chance=%0b short=%0b, %s",
						want.idx, want.chance_hit, want.over_sum,
						$sformatf("got idx=%0d chance=%0b short=%0b", idx, hit, over));
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wr_en = 1'b0;
	logic [wrs_pkg::CNT_W-1:0]     cfg_wr_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [1:0]                    command = wrs_pkg::CMD_WRITE;
	logic [wrs_pkg::IDX_OUT_W-1:0] entry_index = '0;
	logic [wrs_pkg::DATA_W-1:0]    weight_value = '0;
	logic [wrs_pkg::DATA_W-1:0]    chance_value = '0;
	logic [wrs_pkg::DATA_W-1:0]    draw = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [wrs_pkg::IDX_OUT_W-1:0] selected_index;
	logic                          chance_true;
	logic                          sum_short;

	pick_tracker tracker = new();
	bit          written_entry [NUM_OPTIONS];
	int unsigned burst_left = 0;

	weighted_random_select_unit #(
		.MAX_OPTIONS(NUM_OPTIONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.entry_index(entry_index),
		.weight_value(weight_value),
		.chance_value(chance_value),
		.draw(draw),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.selected_index(selected_index),
		.chance_true(chance_true),
		.sum_short(sum_short)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The result is checked before the input so a chance test never meets its own result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) tracker.check_pick(selected_index, chance_true, sum_short);
			if (in_valid && !in_stall)
				tracker.take_command(command, entry_index, weight_value, chance_value, draw);
		end
	end

	function automatic logic [wrs_pkg::DATA_W-1:0] pick_weight(input int unsigned n);
		int unsigned r;
		int unsigned span;
		r = $urandom_range(0, 19);
		span = (n == 0) ? 16383 : 20000 / n;
		if (span > 16383) span = 16383;
		if (r < 3) return '0;
		if (r < 5) return wrs_pkg::SCALE;
		if (r < 8) return data_t'($urandom_range(0, 16383));
		return data_t'($urandom_range(0, span));
	endfunction

	function automatic logic [wrs_pkg::DATA_W-1:0] random_draw();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r < 3) return data_t'($urandom_range(0, 16383));
		return data_t'($urandom_range(1, 10000));
	endfunction

	task automatic send_item(input logic [1:0] cmd, input logic [wrs_pkg::IDX_OUT_W-1:0] idx,
			input logic [wrs_pkg::DATA_W-1:0] wv, input logic [wrs_pkg::DATA_W-1:0] cv,
			input logic [wrs_pkg::DATA_W-1:0] dr);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= cmd;
		entry_index <= idx;
		weight_value <= wv;
		chance_value <= cv;
		draw <= dr;
		if (cmd == wrs_pkg::CMD_WRITE) written_entry[idx] = 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Waits until every expected result is out, then lets a full walk of the chain pass.
	task automatic drain();
		int unsigned guard;
		guard = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (NUM_OPTIONS + 8) @(posedge clk);
	endtask

	task automatic run_phase(input logic [wrs_pkg::CNT_W-1:0] cnt, input int unsigned items);
		int unsigned                n_eff;
		int unsigned                done;
		int unsigned                r;
		logic [1:0]                 cmd;
		logic [wrs_pkg::DATA_W-1:0] wv;
		logic [wrs_pkg::DATA_W-1:0] cv;
		logic [wrs_pkg::DATA_W-1:0] dr;
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cnt;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.opt_count = cnt;
		n_eff = (cnt > NUM_OPTIONS) ? NUM_OPTIONS : cnt;
		// A select may walk every entry below the option count, so all of them get a weight first.
		for (int i = 0; i < n_eff; i++)
			if (!written_entry[i])
				send_item(wrs_pkg::CMD_WRITE, i[wrs_pkg::IDX_OUT_W-1:0], pick_weight(n_eff),
					data_t'($urandom_range(0, 16383)), data_t'($urandom_range(0, 16383)));
		done = 0;
		while (done < items) begin
			r = $urandom_range(0, 99);
			if (r < 45) cmd = wrs_pkg::CMD_SELECT;
			else if (r < 75) cmd = wrs_pkg::CMD_CHANCE;
			else if (r < 95) cmd = wrs_pkg::CMD_WRITE;
			else cmd = CMD_UNUSED;
			wv = data_t'($urandom_range(0, 16383));
			cv = data_t'($urandom_range(0, 16383));
			dr = data_t'($urandom_range(0, 16383));
			case (cmd)
				wrs_pkg::CMD_WRITE: wv = pick_weight(n_eff);
				wrs_pkg::CMD_SELECT: dr = random_draw();
				wrs_pkg::CMD_CHANCE: begin
					r = $urandom_range(0, 9);
					if (r == 0) cv = '0;
					else if (r == 1) cv = wrs_pkg::SCALE;
					else if (r > 3) cv = data_t'($urandom_range(1, 10000));
					// Draws right at the boundary catch an off-by-one in the compare.
					dr = ($urandom_range(0, 9) < 4) ? data_t'(cv + $urandom_range(0, 2) - 1)
						: random_draw();
				end
				default: ;
			endcase
			send_item(cmd, idx_t'($urandom_range(0, NUM_OPTIONS - 1)), wv, cv, dr);
			if (cmd != CMD_UNUSED) done++;
		end
	endtask

	initial begin : result_sink
		int unsigned mode;
		int unsigned span;
		bit          held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			// One long hold-off lets the result register fill and back up into the input.
			if (!held && tracker.checked >= HOLD_AFTER) begin
				held = 1'b1;
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 4);
			span = $urandom_range(10, 300);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0, 1: out_stall <= 1'b0;
					2: out_stall <= ($urandom_range(0, 3) == 0);
					3: out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		logic [wrs_pkg::CNT_W-1:0] cnt;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset option count of one.
		send_item(wrs_pkg::CMD_WRITE, 0, 14'd16383, 0, 0);
		send_item(wrs_pkg::CMD_SELECT, 0, 0, 0, wrs_pkg::SCALE);
		send_item(wrs_pkg::CMD_SELECT, 0, 0, 0, 14'd16383);
		send_item(wrs_pkg::CMD_SELECT, 0, 0, 0, 0);
		send_item(wrs_pkg::CMD_SELECT, 0, 0, 0, 1);
		send_item(wrs_pkg::CMD_WRITE, 0, 0, 0, 0);
		send_item(wrs_pkg::CMD_SELECT, 0, 0, 0, 0);
		send_item(wrs_pkg::CMD_SELECT, 0, 0, 0, 1);
		send_item(wrs_pkg::CMD_CHANCE, 0, 0, 0, 0);
		send_item(wrs_pkg::CMD_CHANCE, 0, 0, wrs_pkg::SCALE, 0);
		send_item(wrs_pkg::CMD_CHANCE, 0, 0, wrs_pkg::SCALE, wrs_pkg::SCALE);
		send_item(wrs_pkg::CMD_CHANCE, 0, 0, 14'd9999, wrs_pkg::SCALE);
		send_item(wrs_pkg::CMD_CHANCE, 0, 0, 14'd16383, 14'd16383);
		send_item(wrs_pkg::CMD_CHANCE, 0, 0, 1, 1);
		send_item(CMD_UNUSED, 7'h7f, 14'h3fff, 14'h3fff, 14'h3fff);
		send_item(wrs_pkg::CMD_WRITE, 7'h7f, 14'd10001, 0, 0);
		send_item(wrs_pkg::CMD_WRITE, 1, 14'd9999, 0, 0);
		send_item(wrs_pkg::CMD_WRITE, 0, 14'd3, 0, 0);
		send_item(wrs_pkg::CMD_SELECT, 0, 0, 0, 14'd3);
		send_item(wrs_pkg::CMD_SELECT, 0, 0, 0, 14'd4);

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: cnt = 8'd2;
				1: cnt = 8'd255;
				2: cnt = 8'd0;
				3: cnt = 8'd128;
				4: cnt = 8'd1;
				5, 8: cnt = cnt_t'($urandom_range(3, 127));
				6: cnt = cnt_t'($urandom_range(129, 254));
				7: cnt = 8'd64;
				default: cnt = cnt_t'($urandom_range(0, 255));
			endcase
			run_phase(cnt, PHASE_ITEMS);
		end

		drain();
		if (tracker.fail_count == 0 && tracker.outstanding() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/wrs_pkg.sv
design/wrs_cell.sv
design/weighted_random_select_unit.sv
bench/tb_weighted_random_select_unit.sv
